// File: sv/ilx_pkg.sv
package ilx_pkg;

  localparam int unsigned CntW      = 16;
  localparam int unsigned QuoW      = 11;
  localparam int unsigned RemW      = CntW + 1;
  localparam int unsigned GainShift = 4;
  localparam int unsigned ScW       = CntW + GainShift;
  localparam int unsigned CoefW     = 10;
  localparam int unsigned ProdW     = ScW + CoefW;
  localparam int unsigned LuxFrac   = 14;
  localparam int unsigned LuxW      = 16;
  localparam int unsigned BrightW   = 7;
  localparam int unsigned NBands    = 8;
  localparam int unsigned SelW      = 3;

  localparam logic [BrightW-1:0] BrightCap = 7'd100;

  localparam logic [QuoW-1:0] BAND_LIMIT [0:NBands-2] = '{
    11'h040, 11'h080, 11'h0c0, 11'h100, 11'h138, 11'h19a, 11'h29a
  };

  localparam logic [CoefW-1:0] BAND_OFFSET [0:NBands-1] = '{
    10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
  };

  localparam logic [CoefW-1:0] BAND_SLOPE [0:NBands-1] = '{
    10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
  };

  // one request moving down the divider chain
  typedef struct packed {
    logic [CntW-1:0] bb;
    logic [CntW-1:0] ir;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            ovf;
  } div_t;

  // first band whose limit is not below the ratio, last band on overflow
  function automatic logic [SelW-1:0] band_sel(logic [QuoW-1:0] rq, logic ovf);
    logic [SelW-1:0] sel;
    sel = SelW'(NBands - 1);
    for (int i = NBands - 2; i >= 0; i--) begin
      if (rq <= BAND_LIMIT[i]) begin
        sel = SelW'(i);
      end
    end
    if (ovf) begin
      sel = SelW'(NBands - 1);
    end
    return sel;
  endfunction

endpackage

// File: sv/ilx_div_cell.sv
module ilx_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ilx_pkg::div_t data_i,
  output logic          valid_o,
  output ilx_pkg::div_t data_o
);

  logic [ilx_pkg::RemW-1:0] dvs;
  logic [ilx_pkg::RemW-1:0] diff;
  logic                     fit;
  ilx_pkg::div_t            data_d;
  logic                     valid_q;
  ilx_pkg::div_t            data_q;

  // one restoring step: compare, subtract, shift the partial remainder up
  always_comb begin
    dvs    = {1'b0, data_i.bb};
    fit    = (data_i.rem >= dvs);
    diff   = fit ? (data_i.rem - dvs) : data_i.rem;
    data_d = data_i;
    data_d.rem = {diff[ilx_pkg::RemW-2:0], 1'b0};
    data_d.quo = {data_i.quo[ilx_pkg::QuoW-2:0], fit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/ilx_lux_stage.sv
module ilx_lux_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  ilx_pkg::div_t               data_i,
  output logic                        valid_o,
  output logic [ilx_pkg::ProdW-1:0]   pos_o,
  output logic [ilx_pkg::ProdW-1:0]   neg_o,
  output logic [ilx_pkg::BrightW-1:0] bright_o
);

  logic [ilx_pkg::QuoW:0]      rq_sum;
  logic [ilx_pkg::QuoW-1:0]    rq;
  logic [ilx_pkg::SelW-1:0]    sel;
  logic [ilx_pkg::ScW-1:0]     bbs;
  logic [ilx_pkg::ScW-1:0]     irs;
  logic [ilx_pkg::CntW-1:0]    wrap;
  logic [ilx_pkg::ProdW-1:0]   pos_d;
  logic [ilx_pkg::ProdW-1:0]   neg_d;
  logic [ilx_pkg::BrightW-1:0] bright_d;
  logic                        valid_q;
  logic [ilx_pkg::ProdW-1:0]   pos_q;
  logic [ilx_pkg::ProdW-1:0]   neg_q;
  logic [ilx_pkg::BrightW-1:0] bright_q;

  always_comb begin
    // ratio rounded half up from the doubled quotient
    rq_sum = {1'b0, data_i.quo} + (ilx_pkg::QuoW+1)'(1);
    rq     = rq_sum[ilx_pkg::QuoW:1];
    sel    = ilx_pkg::band_sel(rq, data_i.ovf);
    bbs    = {data_i.bb, {ilx_pkg::GainShift{1'b0}}};
    irs    = {data_i.ir, {ilx_pkg::GainShift{1'b0}}};
    pos_d  = ilx_pkg::ProdW'(bbs) * ilx_pkg::ProdW'(ilx_pkg::BAND_OFFSET[sel]);
    neg_d  = ilx_pkg::ProdW'(irs) * ilx_pkg::ProdW'(ilx_pkg::BAND_SLOPE[sel]);
    wrap   = data_i.bb - data_i.ir;
    if (wrap > ilx_pkg::CntW'(ilx_pkg::BrightCap)) begin
      bright_d = ilx_pkg::BrightCap;
    end else begin
      bright_d = wrap[ilx_pkg::BrightW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q    <= pos_d;
      neg_q    <= neg_d;
      bright_q <= bright_d;
    end
  end

  assign valid_o  = valid_q;
  assign pos_o    = pos_q;
  assign neg_o    = neg_q;
  assign bright_o = bright_q;

endmodule

// File: sv/illuminance_lux_from_light_channels.sv
// channel | signals                                      | direction
// in      | in_valid_i, in_ready_o, broadband_count_i,    | request in
//         | infrared_count_i                             |
// out     | out_valid_o, out_ready_i, lux_o, brightness_o| result out
//
// one request per cycle while the chain is not held; a request passes 11 divider
// cells (one quotient bit each), the band and multiply stage, the output register
// the whole chain advances together; it holds only while a result waits and
// out_ready_i is low, and in_ready_o follows that same enable
// reset clears the valid bits of every stage; payload registers are not reset
module illuminance_lux_from_light_channels (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ilx_pkg::CntW-1:0]    broadband_count_i,
  input  logic [ilx_pkg::CntW-1:0]    infrared_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ilx_pkg::LuxW-1:0]    lux_o,
  output logic [ilx_pkg::BrightW-1:0] brightness_o
);

  logic                        en;
  logic                        cell_valid [0:ilx_pkg::QuoW];
  ilx_pkg::div_t               cell_data  [0:ilx_pkg::QuoW];
  logic                        mul_valid;
  logic [ilx_pkg::ProdW-1:0]   mul_pos;
  logic [ilx_pkg::ProdW-1:0]   mul_neg;
  logic [ilx_pkg::BrightW-1:0] mul_bright;
  logic [ilx_pkg::ProdW-1:0]   diff;
  logic [ilx_pkg::ProdW:0]     rnd;
  logic [ilx_pkg::ProdW-ilx_pkg::LuxFrac:0] shifted;
  logic [ilx_pkg::LuxW-1:0]    lux_d;
  logic                        out_valid_q;
  logic [ilx_pkg::LuxW-1:0]    lux_q;
  logic [ilx_pkg::BrightW-1:0] bright_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // quotient stays below 2^11 unless infrared is at least twice broadband
  always_comb begin
    cell_valid[0]    = in_valid_i;
    cell_data[0].bb  = broadband_count_i;
    cell_data[0].ir  = infrared_count_i;
    cell_data[0].rem = {1'b0, infrared_count_i};
    cell_data[0].quo = '0;
    cell_data[0].ovf = ({1'b0, infrared_count_i} >= {broadband_count_i, 1'b0});
  end

  for (genvar g = 0; g < ilx_pkg::QuoW; g++) begin : g_cell
    ilx_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[g]),
      .data_i  (cell_data[g]),
      .valid_o (cell_valid[g+1]),
      .data_o  (cell_data[g+1])
    );
  end

  ilx_lux_stage u_lux (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (cell_valid[ilx_pkg::QuoW]),
    .data_i   (cell_data[ilx_pkg::QuoW]),
    .valid_o  (mul_valid),
    .pos_o    (mul_pos),
    .neg_o    (mul_neg),
    .bright_o (mul_bright)
  );

  // clamp at zero, round half up, drop the fraction, saturate
  always_comb begin
    diff    = (mul_pos > mul_neg) ? (mul_pos - mul_neg) : '0;
    rnd     = {1'b0, diff} + ((ilx_pkg::ProdW+1)'(1) << (ilx_pkg::LuxFrac - 1));
    shifted = rnd[ilx_pkg::ProdW:ilx_pkg::LuxFrac];
    if (shifted[ilx_pkg::ProdW-ilx_pkg::LuxFrac:ilx_pkg::LuxW] != '0) begin
      lux_d = '1;
    end else begin
      lux_d = shifted[ilx_pkg::LuxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= mul_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lux_q    <= lux_d;
      bright_q <= mul_bright;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lux_o        = lux_q;
  assign brightness_o = bright_q;

  a_bright_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> brightness_o <= ilx_pkg::BrightCap)
    else $error("brightness above cap");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[ilx_pkg::QuoW] && !cell_data[ilx_pkg::QuoW].ovf)
      |-> cell_data[ilx_pkg::QuoW].rem[ilx_pkg::RemW-1:1] < cell_data[ilx_pkg::QuoW].bb)
    else $error("divider remainder not below divisor");

  a_ovf_dark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[ilx_pkg::QuoW] && cell_data[ilx_pkg::QuoW].ovf && en)
      |=> mul_pos == '0 && mul_neg == '0)
    else $error("overflowed ratio did not select the dark band");

endmodule

// File: bench/illuminance_lux_from_light_channels_tb.sv
module illuminance_lux_from_light_channels_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom  = 1450;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter  = 400;
  localparam int unsigned NumBands   = 8;
  localparam int unsigned BrightMax  = 100;

  // ratio limits in 2^-9 units, offset and slope in 2^-14 lux units
  localparam logic [15:0] RATIO_EDGE [0:NumBands-2] = '{
    16'h0040, 16'h0080, 16'h00c0, 16'h0100, 16'h0138, 16'h019a, 16'h029a
  };
  localparam logic [15:0] BB_WEIGHT [0:NumBands-1] = '{
    16'h01f2, 16'h0214, 16'h023f, 16'h0270, 16'h016f, 16'h00d2, 16'h0018, 16'h0000
  };
  localparam logic [15:0] IR_WEIGHT [0:NumBands-1] = '{
    16'h01be, 16'h02d1, 16'h037b, 16'h03fe, 16'h01fc, 16'h00fb, 16'h0012, 16'h0000
  };

  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  typedef struct packed {
    logic [ilx_pkg::LuxW-1:0]    lux;
    logic [ilx_pkg::BrightW-1:0] bright;
  } reading_t;

  typedef struct packed {
    logic [ilx_pkg::CntW-1:0] bb;
    logic [ilx_pkg::CntW-1:0] ir;
    bit                       typed;
    reading_t                 want;
  } light_row_t;

  localparam int unsigned NumRows = 25;
  localparam light_row_t LIGHT_ROWS [0:NumRows-1] = '{
    '{16'd0,     16'd0,     TYPED,   '{16'd0,     7'd0}},
    '{16'd0,     16'd65535, TYPED,   '{16'd0,     7'd1}},
    '{16'd0,     16'd5,     TYPED,   '{16'd0,     7'd100}},
    '{16'd65535, 16'd0,     TYPED,   '{16'd31872, 7'd100}},
    '{16'd65535, 16'd65535, TYPED,   '{16'd384,   7'd0}},
    '{16'd1,     16'd65535, TYPED,   '{16'd0,     7'd2}},
    '{16'd100,   16'd0,     PREDICT, '{16'd0,     7'd0}},
    '{16'd101,   16'd0,     PREDICT, '{16'd0,     7'd0}},
    '{16'd300,   16'd199,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd64,    PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd65,    PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd128,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd129,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd192,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd193,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd256,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd257,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd312,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd313,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd410,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd411,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd666,   PREDICT, '{16'd0,     7'd0}},
    '{16'd512,   16'd667,   PREDICT, '{16'd0,     7'd0}},
    '{16'd3,     16'd1,     PREDICT, '{16'd0,     7'd0}},
    '{16'd65535, 16'd1,     PREDICT, '{16'd0,     7'd0}}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ilx_pkg::CntW-1:0]    bb_cnt = '0;
  logic [ilx_pkg::CntW-1:0]    ir_cnt = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ilx_pkg::LuxW-1:0]    lux;
  logic [ilx_pkg::BrightW-1:0] bright;

  reading_t    pending_readings [$];
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  bit          burst = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ready_gap = 0;
  int unsigned ready_roll;

  illuminance_lux_from_light_channels i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .broadband_count_i (bb_cnt),
    .infrared_count_i  (ir_cnt),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .lux_o             (lux),
    .brightness_o      (bright)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic reading_t lux_from_counts(input logic [15:0] bb, input logic [15:0] ir);
    logic [31:0] bb_sc;
    logic [31:0] ir_sc;
    logic [31:0] ratio2;
    logic [31:0] ratio;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] acc;
    logic [15:0] diff;
    int unsigned band;
    bit          found;
    reading_t    r;
    bb_sc = {12'd0, bb, 4'd0};
    ir_sc = {12'd0, ir, 4'd0};
    ratio2 = 32'd0;
    if (bb_sc != 32'd0) begin
      ratio2 = (ir_sc << 10) / bb_sc;
    end
    ratio = (ratio2 + 32'd1) >> 1;
    band = NumBands - 1;
    found = 1'b0;
    for (int i = 0; i < NumBands - 1; i++) begin
      if (!found && ratio <= {16'd0, RATIO_EDGE[i]}) begin
        band = i;
        found = 1'b1;
      end
    end
    pos = {32'd0, bb_sc} * {48'd0, BB_WEIGHT[band]};
    neg = {32'd0, ir_sc} * {48'd0, IR_WEIGHT[band]};
    acc = (pos > neg) ? (pos - neg) : 64'd0;
    acc = (acc + (64'd1 << 13)) >> 14;
    if (acc > 64'hffff) begin
      acc = 64'hffff;
    end
    r.lux = acc[15:0];
    diff = bb - ir;
    r.bright = (diff > BrightMax) ? 7'(BrightMax) : diff[6:0];
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_request(input logic [15:0] bb, input logic [15:0] ir, input reading_t want);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    bb_cnt <= bb;
    ir_cnt <= ir;
    do @(posedge clk_i); while (!in_ready);
    pending_readings.push_back(want);
    n_accepted++;
  endtask

  // random counts, shaped to spread over bands, band edges and small differences
  task automatic random_counts(output logic [15:0] bb, output logic [15:0] ir);
    int unsigned kind;
    logic [31:0] b;
    logic [31:0] t;
    kind = $urandom_range(0, 99);
    b = $urandom_range(1, 65535) >> $urandom_range(0, 15);
    if (b == 0) begin
      b = 1;
    end
    if (kind < 30) begin
      bb = 16'($urandom_range(0, 65535));
      ir = 16'($urandom_range(0, 65535));
    end else if (kind < 55) begin
      t = (b * $urandom_range(0, 1400)) >> 10;
      bb = b[15:0];
      ir = (t > 65535) ? 16'hffff : t[15:0];
    end else if (kind < 70) begin
      ir = 16'($urandom_range(0, 65535));
      bb = ir + 16'($urandom_range(0, 110));
    end else if (kind < 80) begin
      t = ((b * RATIO_EDGE[$urandom_range(0, NumBands - 2)]) >> 9) + $urandom_range(0, 2);
      bb = b[15:0];
      ir = (t > 65535) ? 16'hffff : t[15:0];
    end else if (kind < 88) begin
      bb = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
      ir = (bb == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
    end else begin
      bb = b[15:0];
      ir = 16'($urandom_range(0, 65535));
    end
  endtask

  initial begin
    logic [15:0] bb;
    logic [15:0] ir;
    reading_t    want;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumRows; i++) begin
      want = LIGHT_ROWS[i].typed ? LIGHT_ROWS[i].want
                                 : lux_from_counts(LIGHT_ROWS[i].bb, LIGHT_ROWS[i].ir);
      offer_request(LIGHT_ROWS[i].bb, LIGHT_ROWS[i].ir, want);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 100 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      random_counts(bb, ir);
      offer_request(bb, ir, lux_from_counts(bb, ir));
    end
    in_valid <= 1'b0;
    burst = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("illuminance_lux_from_light_channels_tb: PASS");
    end else begin
      $display("illuminance_lux_from_light_channels_tb: FAIL");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold so the pipeline backs up
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && n_accepted >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else if (burst) begin
      out_ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        ready_gap = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("result with no request pending: lux %0d brightness %0d", lux, bright);
        n_errors++;
      end else begin
        want = pending_readings.pop_front();
        if (lux !== want.lux) begin
          $error("lux: expected %0d, got %0d", want.lux, lux);
          n_errors++;
        end
        if (bright !== want.bright) begin
          $error("brightness: expected %0d, got %0d", want.bright, bright);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("illuminance_lux_from_light_channels_tb: FAIL");
      $finish;
    end
  end

endmodule
